### sv/bcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcm_pkg;

  // Curve table geometry.
  localparam int MaxPoints = 16;
  localparam int PtIdxW    = $clog2(MaxPoints);

  // Fixed field widths.
  localparam int CamW  = 8;
  localparam int ScrW  = 7;
  localparam int CntW  = 5;
  localparam int IdxInW = 4;
  localparam int RegIdxW = 3;

  localparam logic [ScrW-1:0] PctMax = ScrW'(100);

  // Divider: product of an 8-bit and a 7-bit magnitude.
  localparam int ProdW    = CamW + ScrW;
  localparam int DivCntW  = $clog2(ProdW);

  // Queue between the front and back ends.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [RegIdxW-1:0] {
    RegCameraLow   = 3'd0,
    RegCameraHigh  = 3'd1,
    RegScreenLow   = 3'd2,
    RegScreenHigh  = 3'd3,
    RegCurveEnable = 3'd4,
    RegCurveCount  = 3'd5
  } reg_idx_e;

  typedef enum logic {
    OpMap   = 1'b0,
    OpPoint = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KindWrite  = 2'd0,
    KindCurve  = 2'd1,
    KindLinear = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StIdle  = 3'd0,
    StFirst = 3'd1,
    StScan  = 3'd2,
    StMul   = 3'd3,
    StDiv   = 3'd4,
    StRes   = 3'd5
  } back_state_e;

  typedef struct packed {
    logic [CamW-1:0] camera_low;
    logic [CamW-1:0] camera_high;
    logic [ScrW-1:0] screen_low;
    logic [ScrW-1:0] screen_high;
    logic            curve_enable;
    logic [CntW-1:0] curve_count;
  } cfg_t;

  typedef struct packed {
    logic [CamW-1:0] cam;
    logic [ScrW-1:0] scr;
  } point_t;

  typedef struct packed {
    kind_e             kind;
    logic [CamW-1:0]   level;
    logic [PtIdxW-1:0] idx;
    point_t            pt;
    logic [PtIdxW-1:0] last;
  } job_t;

endpackage

`default_nettype wire

### sv/bcm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bcm_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bcm_pkg::cfg_t                cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         op_i,
  input  wire logic [bcm_pkg::CamW-1:0]     camera_level_i,
  input  wire logic [bcm_pkg::IdxInW-1:0]   point_index_i,
  input  wire logic [bcm_pkg::CamW-1:0]     point_camera_i,
  input  wire logic [bcm_pkg::ScrW-1:0]     point_screen_i,
  output logic                              push_valid_o,
  input  wire logic                         push_ready_i,
  output bcm_pkg::job_t                     job_o
);

  logic          slot_valid_q, slot_valid_d;
  bcm_pkg::job_t job_q, job_d;
  logic          accept;
  logic          drop;

  assign in_ready_o = !slot_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the word: point writes outside the table are dropped here, map
  // words pick curve or linear mode from the configuration at hand.
  always_comb begin
    int cnt;
    cnt         = int'(cfg_i.curve_count);
    if (cnt > bcm_pkg::MaxPoints) cnt = bcm_pkg::MaxPoints;
    drop        = 1'b0;
    job_d.level = camera_level_i;
    job_d.idx   = bcm_pkg::PtIdxW'(point_index_i);
    job_d.pt    = '{cam: point_camera_i, scr: point_screen_i};
    job_d.last  = bcm_pkg::PtIdxW'(cnt - 1);
    if (bcm_pkg::op_e'(op_i) == bcm_pkg::OpPoint) begin
      job_d.kind = bcm_pkg::KindWrite;
      drop       = int'(point_index_i) >= bcm_pkg::MaxPoints;
    end else if (cfg_i.curve_enable && cnt >= 2) begin
      job_d.kind = bcm_pkg::KindCurve;
    end else begin
      job_d.kind = bcm_pkg::KindLinear;
    end
  end

  always_comb begin
    slot_valid_d = slot_valid_q;
    if (accept) begin
      slot_valid_d = !drop;
    end else if (push_ready_i) begin
      slot_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign push_valid_o = slot_valid_q;
  assign job_o        = job_q;

endmodule

`default_nettype wire

### sv/bcm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bcm_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire bcm_pkg::job_t job_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output bcm_pkg::job_t      job_o
);

  bcm_pkg::job_t                   entry_q [bcm_pkg::QueueDepth];
  logic [bcm_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [bcm_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [bcm_pkg::QCntW-1:0]       count_q, count_d;
  logic                            push, pop;

  assign push_ready_o = count_q != bcm_pkg::QCntW'(bcm_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign job_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (int'(wr_ptr_q) == bcm_pkg::QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == bcm_pkg::QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

### sv/bcm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bcm_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire bcm_pkg::cfg_t            cfg_i,
  input  wire logic                     pop_valid_i,
  output logic                          pop_ready_o,
  input  wire bcm_pkg::job_t            job_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [bcm_pkg::ScrW-1:0]      screen_level_o
);

  bcm_pkg::back_state_e state_q, state_d;

  bcm_pkg::point_t curve_mem [bcm_pkg::MaxPoints];
  bcm_pkg::point_t rd_q;
  logic [bcm_pkg::PtIdxW-1:0] rd_addr;
  logic                       mem_we;

  logic [bcm_pkg::PtIdxW-1:0]  idx_q, idx_d;
  logic [bcm_pkg::PtIdxW-1:0]  last_q, last_d;
  logic [bcm_pkg::CamW-1:0]    x_q, x_d;
  bcm_pkg::point_t             prev_q, prev_d;
  bcm_pkg::point_t             first_q, first_d;
  logic [bcm_pkg::CamW-1:0]    dx_q, dx_d;
  logic [bcm_pkg::CamW-1:0]    den_q, den_d;
  logic [bcm_pkg::ScrW-1:0]    y0_q, y0_d;
  logic [bcm_pkg::ScrW-1:0]    dy_q, dy_d;
  logic                        neg_q, neg_d;
  logic [bcm_pkg::ProdW-1:0]   quo_q, quo_d;
  logic [bcm_pkg::CamW-1:0]    rem_q, rem_d;
  logic [bcm_pkg::DivCntW-1:0] step_q, step_d;

  logic                        out_valid_q, out_valid_d;
  logic [bcm_pkg::ScrW-1:0]    out_q;

  logic                        take;
  logic                        hit;
  logic                        at_end;
  logic                        zero_width;
  logic                        lin_flat;
  logic                        res_free;
  logic                        res_load;
  logic                        div_done;
  logic [bcm_pkg::CamW-1:0]    lin_c;
  logic [bcm_pkg::CamW:0]      trial;
  logic signed [bcm_pkg::ScrW+1:0] sum;
  logic [bcm_pkg::ScrW-1:0]    result;

  assign take       = pop_valid_i && pop_ready_o;
  assign hit        = (x_q >= prev_q.cam) && (x_q <= rd_q.cam);
  assign at_end     = idx_q == last_q;
  assign zero_width = rd_q.cam == prev_q.cam;
  assign lin_flat   = cfg_i.camera_low >= cfg_i.camera_high;
  assign res_free   = !out_valid_q || out_ready_i;
  assign div_done   = step_q == bcm_pkg::DivCntW'(bcm_pkg::ProdW - 1);

  // Linear mode clamps the level into the camera bounds first.
  assign lin_c = (job_i.level > cfg_i.camera_high) ? cfg_i.camera_high :
                 (job_i.level < cfg_i.camera_low)  ? cfg_i.camera_low  : job_i.level;

  // One restoring shift-subtract step of the divider.
  assign trial = {rem_q, quo_q[bcm_pkg::ProdW-1]};

  // The quotient never exceeds the screen difference, so it fits the screen width.
  assign sum = neg_q ? $signed({2'b00, y0_q}) - $signed({2'b00, quo_q[bcm_pkg::ScrW-1:0]})
                     : $signed({2'b00, y0_q}) + $signed({2'b00, quo_q[bcm_pkg::ScrW-1:0]});
  assign result = (sum < 0) ? '0 :
                  (sum > $signed({2'b00, bcm_pkg::PctMax})) ? bcm_pkg::PctMax :
                  sum[bcm_pkg::ScrW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcm_pkg::StIdle: begin
        if (pop_valid_i) begin
          unique case (job_i.kind)
            bcm_pkg::KindCurve:  state_d = bcm_pkg::StFirst;
            bcm_pkg::KindLinear: state_d = lin_flat ? bcm_pkg::StRes : bcm_pkg::StMul;
            default:             state_d = bcm_pkg::StIdle;
          endcase
        end
      end
      bcm_pkg::StFirst: state_d = bcm_pkg::StScan;
      bcm_pkg::StScan: begin
        if (hit) begin
          state_d = zero_width ? bcm_pkg::StRes : bcm_pkg::StMul;
        end else if (at_end) begin
          state_d = bcm_pkg::StRes;
        end
      end
      bcm_pkg::StMul: state_d = bcm_pkg::StDiv;
      bcm_pkg::StDiv: begin
        if (div_done) state_d = bcm_pkg::StRes;
      end
      bcm_pkg::StRes: begin
        if (res_free) state_d = bcm_pkg::StIdle;
      end
      default: state_d = bcm_pkg::StIdle;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop_ready_o = 1'b0;
    mem_we      = 1'b0;
    res_load    = 1'b0;
    rd_addr     = '0;
    unique case (state_q)
      bcm_pkg::StIdle: begin
        pop_ready_o = 1'b1;
        mem_we      = pop_valid_i && (job_i.kind == bcm_pkg::KindWrite);
      end
      bcm_pkg::StFirst: rd_addr = bcm_pkg::PtIdxW'(1);
      bcm_pkg::StScan:  rd_addr = idx_q + 1'b1;
      bcm_pkg::StRes:   res_load = res_free;
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    idx_d   = idx_q;
    last_d  = last_q;
    x_d     = x_q;
    prev_d  = prev_q;
    first_d = first_q;
    dx_d    = dx_q;
    den_d   = den_q;
    y0_d    = y0_q;
    dy_d    = dy_q;
    neg_d   = neg_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    unique case (state_q)
      bcm_pkg::StIdle: begin
        x_d    = job_i.level;
        last_d = job_i.last;
        idx_d  = '0;
        if (take && job_i.kind == bcm_pkg::KindLinear) begin
          dx_d  = lin_c - cfg_i.camera_low;
          den_d = cfg_i.camera_high - cfg_i.camera_low;
          y0_d  = cfg_i.screen_low;
          neg_d = cfg_i.screen_high < cfg_i.screen_low;
          dy_d  = (cfg_i.screen_high < cfg_i.screen_low) ?
                  cfg_i.screen_low - cfg_i.screen_high :
                  cfg_i.screen_high - cfg_i.screen_low;
          quo_d = '0;
        end
      end
      bcm_pkg::StFirst: begin
        first_d = rd_q;
        prev_d  = rd_q;
        idx_d   = bcm_pkg::PtIdxW'(1);
      end
      bcm_pkg::StScan: begin
        quo_d = '0;
        if (hit) begin
          dx_d  = x_q - prev_q.cam;
          den_d = rd_q.cam - prev_q.cam;
          y0_d  = prev_q.scr;
          neg_d = rd_q.scr < prev_q.scr;
          dy_d  = (rd_q.scr < prev_q.scr) ? prev_q.scr - rd_q.scr : rd_q.scr - prev_q.scr;
        end else if (at_end) begin
          // Level lies off the curve: take the first or the last end value.
          y0_d  = (x_q < first_q.cam) ? first_q.scr : rd_q.scr;
          neg_d = 1'b0;
        end else begin
          prev_d = rd_q;
          idx_d  = idx_q + 1'b1;
        end
      end
      bcm_pkg::StMul: begin
        quo_d  = bcm_pkg::ProdW'(dx_q) * bcm_pkg::ProdW'(dy_q);
        rem_d  = '0;
        step_d = '0;
      end
      bcm_pkg::StDiv: begin
        step_d = step_q + 1'b1;
        if (trial >= {1'b0, den_q}) begin
          rem_d = bcm_pkg::CamW'(trial - {1'b0, den_q});
          quo_d = {quo_q[bcm_pkg::ProdW-2:0], 1'b1};
        end else begin
          rem_d = trial[bcm_pkg::CamW-1:0];
          quo_d = {quo_q[bcm_pkg::ProdW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcm_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    last_q  <= last_d;
    x_q     <= x_d;
    prev_q  <= prev_d;
    first_q <= first_d;
    dx_q    <= dx_d;
    den_q   <= den_d;
    y0_q    <= y0_d;
    dy_q    <= dy_d;
    neg_q   <= neg_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    if (res_load) begin
      out_q <= result;
    end
  end

  // Curve table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      curve_mem[job_i.idx] <= job_i.pt;
    end
    rd_q <= curve_mem[rd_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign screen_level_o = out_q;

endmodule

`default_nettype wire

### sv/brightness_curve_mapper.sv
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_we_i                   cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_ready_o    op_i, camera_level_i, point_index_i,
//                                                 point_camera_i, point_screen_i
// out       out        out_valid_o / out_ready_i  screen_level_o
//
// A point write is taken in the idle state and leaves the back end idle. A map word in
// curve mode scans up to a full 16-point table, one point per cycle through the table's
// single read port, and a shift-subtract divider follows; linear mode skips the scan.
// Reset restores the register defaults and leaves the curve table undefined until
// written. A two-word queue between the front and back ends takes words while the back
// end is busy or its output waits.
`timescale 1ns / 1ps
`default_nettype none

module brightness_curve_mapper (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bcm_pkg::RegIdxW-1:0]    cfg_index_i,
  input  wire logic [bcm_pkg::CamW-1:0]       cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           op_i,
  input  wire logic [bcm_pkg::CamW-1:0]       camera_level_i,
  input  wire logic [bcm_pkg::IdxInW-1:0]     point_index_i,
  input  wire logic [bcm_pkg::CamW-1:0]       point_camera_i,
  input  wire logic [bcm_pkg::ScrW-1:0]       point_screen_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [bcm_pkg::ScrW-1:0]            screen_level_o
);

  bcm_pkg::cfg_t cfg_q, cfg_d;
  bcm_pkg::job_t front_job, queue_job;
  logic          push_valid, push_ready;
  logic          pop_valid, pop_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bcm_pkg::reg_idx_e'(cfg_index_i))
        bcm_pkg::RegCameraLow:   cfg_d.camera_low   = cfg_data_i;
        bcm_pkg::RegCameraHigh:  cfg_d.camera_high  = cfg_data_i;
        bcm_pkg::RegScreenLow:   cfg_d.screen_low   = cfg_data_i[bcm_pkg::ScrW-1:0];
        bcm_pkg::RegScreenHigh:  cfg_d.screen_high  = cfg_data_i[bcm_pkg::ScrW-1:0];
        bcm_pkg::RegCurveEnable: cfg_d.curve_enable = cfg_data_i[0];
        bcm_pkg::RegCurveCount:  cfg_d.curve_count  = cfg_data_i[bcm_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{camera_low:   '0,
                 camera_high:  bcm_pkg::CamW'(100),
                 screen_low:   '0,
                 screen_high:  bcm_pkg::PctMax,
                 curve_enable: 1'b0,
                 curve_count:  '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bcm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .camera_level_i (camera_level_i),
    .point_index_i  (point_index_i),
    .point_camera_i (point_camera_i),
    .point_screen_i (point_screen_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .job_o          (front_job)
  );

  bcm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .job_i        (front_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .job_o        (queue_job)
  );

  bcm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .job_i          (queue_job),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .screen_level_o (screen_level_o)
  );

endmodule

`default_nettype wire

### sv/bcm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bcm_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_o,
  input  wire logic                        op_i,
  input  wire logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  input  wire logic [bcm_pkg::ScrW-1:0]    screen_level_o
);

  logic [3:0] pending_q, pending_d;
  logic       map_in, word_out;

  assign map_in   = in_valid_i && in_ready_o && (bcm_pkg::op_e'(op_i) == bcm_pkg::OpMap);
  assign word_out = out_valid_o && out_ready_i;

  // Map words taken but not yet answered.
  always_comb begin
    pending_d = pending_q;
    if (map_in && !word_out) begin
      pending_d = pending_q + 1'b1;
    end else if (word_out && !map_in) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(screen_level_o))
    else $error("result word changed while stalled");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> screen_level_o <= bcm_pkg::PctMax)
    else $error("screen level above full scale");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result word without a pending map word");

  a_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_in && pending_q == '0 |=> !out_valid_o)
    else $error("result word appeared one cycle after its map word");

endmodule

bind brightness_curve_mapper bcm_checker u_bcm_checker (.*);

`default_nettype wire
